// ===== rtl/assert_macros.svh =====
// assertion macros shared by the metatile run fetch rtl
// every macro samples on clock and is muted while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define MTRF_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// expression must never be true out of reset
`define MTRF_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("forbidden condition seen");

`endif

// ===== rtl/mtrf_pkg.sv =====
// shared types, sizes and codes for the metatile run fetch unit
// no dependencies
package mtrf_pkg;

   localparam int MAP_CELLS  = 4096;
   localparam int DEF_WORDS  = 16384;
   localparam int MAX_RUN    = 64;
   localparam int ENTRY_BITS = 16;

   localparam int MAP_AW  = $clog2(MAP_CELLS);
   localparam int DEF_AW  = $clog2(DEF_WORDS);
   localparam int LEN_W   = $clog2(MAX_RUN + 1);
   // signed tile coordinate with headroom for a run past the 16 bit start
   localparam int COORD_W = 18;
   localparam int UC_W    = COORD_W - 1;
   // sub-tile offset for the largest metatile side (8)
   localparam int SUB_W   = 3;
   // map cell index from 7 bit row times 7 bit width plus 7 bit column
   localparam int CELL_W  = 16;
   // definition word address before the range check
   localparam int DADDR_W = ENTRY_BITS + 8;

   typedef enum logic [1:0] {
      FN_MAP_WR  = 2'd0,
      FN_DEF_WR  = 2'd1,
      FN_ROW_RUN = 2'd2,
      FN_COL_RUN = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CSR_MAP_WIDTH  = 3'd0,
      CSR_MAP_HEIGHT = 3'd1,
      CSR_DEF_LIMIT  = 3'd2,
      CSR_SIDE_LOG2  = 3'd3,
      CSR_FALLBACK   = 3'd4
   } csr_idx_type;

   typedef struct packed {
      func_type           func;
      logic signed [15:0] tile_x;
      logic signed [15:0] tile_y;
      logic [6:0]         run_length;
      logic [13:0]        write_addr;
      logic [15:0]        write_data;
   } req_type;

   typedef struct packed {
      logic [15:0] tile_entry;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  map_width;
      logic [6:0]  map_height;
      logic [10:0] def_limit;
      logic [1:0]  side_log2;
      logic [15:0] fallback_entry;
   } cfg_type;

   // side band that travels with a map read
   typedef struct packed {
      logic             valid;
      logic             last;
      logic             oob;
      logic [SUB_W-1:0] sx;
      logic [SUB_W-1:0] sy;
   } tap_type;

endpackage

// ===== rtl/metatile_tile_run_fetch_unit.sv =====
// metatile run fetch unit: control registers, map and definition rams
// run words pass the cursor, map read, definition read and output registers,
// then leave one word per cycle; busy holds until the last definition read is
// out. each ram's single read port sets one tile per cycle; writes set no busy
// reset: synchronous, loads control register defaults (side_log2 1, rest 0); ram
// contents are undefined until written. words cannot be stalled by the receiver
`include "assert_macros.svh"

module metatile_tile_run_fetch_unit import mtrf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  req_type     req_data,
   output logic        busy,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type               cfg_ff, cfg_in;
   logic                  accept, enabled, run_go;
   logic                  map_we, def_we;
   logic [MAP_AW-1:0]     map_raddr;
   logic [DEF_AW-1:0]     def_raddr;
   logic [ENTRY_BITS-1:0] map_q, def_q, wr_word;
   tap_type               tap;
   logic                  active, pending;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAP_WIDTH:  cfg_in.map_width      = csr_wdata[6:0];
            CSR_MAP_HEIGHT: cfg_in.map_height     = csr_wdata[6:0];
            CSR_DEF_LIMIT:  cfg_in.def_limit      = csr_wdata[10:0];
            CSR_SIDE_LOG2:  cfg_in.side_log2      = csr_wdata[1:0];
            CSR_FALLBACK:   cfg_in.fallback_entry = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_width      <= 7'd0;
         cfg_ff.map_height     <= 7'd0;
         cfg_ff.def_limit      <= 11'd0;
         cfg_ff.side_log2      <= 2'd1;
         cfg_ff.fallback_entry <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign accept  = start && !busy;
   assign enabled = (cfg_ff.map_width != 7'd0) && (cfg_ff.map_height != 7'd0)
                    && (cfg_ff.def_limit != 11'd0) && (cfg_ff.side_log2 != 2'd0);
   assign run_go  = accept && enabled && (req_data.run_length != 7'd0)
                    && ((req_data.func == FN_ROW_RUN) || (req_data.func == FN_COL_RUN));
   assign map_we  = accept && (req_data.func == FN_MAP_WR)
                    && (32'(req_data.write_addr) < MAP_CELLS);
   assign def_we  = accept && (req_data.func == FN_DEF_WR)
                    && (32'(req_data.write_addr) < DEF_WORDS);
   assign wr_word = ENTRY_BITS'(req_data.write_data);

   // hold off new requests until the last map and definition reads are out
   assign busy = active || tap.valid || pending;

   mtrf_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAP_CELLS)) u_map_ram (
      .clock (clock),
      .we    (map_we),
      .waddr (MAP_AW'(req_data.write_addr)),
      .wdata (wr_word),
      .raddr (map_raddr),
      .rdata (map_q)
   );

   mtrf_ram #(.WIDTH(ENTRY_BITS), .DEPTH(DEF_WORDS)) u_def_ram (
      .clock (clock),
      .we    (def_we),
      .waddr (DEF_AW'(req_data.write_addr)),
      .wdata (wr_word),
      .raddr (def_raddr),
      .rdata (def_q)
   );

   mtrf_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .run_go    (run_go),
      .req       (req_data),
      .map_raddr (map_raddr),
      .tap       (tap),
      .active    (active)
   );

   mtrf_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .tap       (tap),
      .map_q     (map_q),
      .def_q     (def_q),
      .def_raddr (def_raddr),
      .pending   (pending),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `MTRF_ASSERT(a_gap_after_last, rsp_valid && rsp_data.last |=> !rsp_valid)

endmodule

// ===== rtl/mtrf_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module mtrf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/mtrf_walk.sv =====
// run sequencer: steps the tile cursor and issues one map read per cycle
// depends on mtrf_pkg and assert_macros.svh
`include "assert_macros.svh"

module mtrf_walk import mtrf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              run_go,
   input  req_type           req,
   output logic [MAP_AW-1:0] map_raddr,
   output tap_type           tap,
   output logic              active
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type                 state_ff, state_in;
   logic signed [COORD_W-1:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [LEN_W-1:0]          left_ff, left_in;
   logic                      col_ff, col_in;
   tap_type                   tap_ff, tap_in;

   logic [LEN_W-1:0]  len_eff;
   logic [UC_W-1:0]   ux, uy, mtx, mty;
   logic              neg, outside, cell_oob;
   logic [CELL_W-1:0] map_cell;
   logic [SUB_W-1:0]  sub_mask;

   always_comb begin
      if (32'(req.run_length) > MAX_RUN) begin
         len_eff = LEN_W'(MAX_RUN);
      end else begin
         len_eff = LEN_W'(req.run_length);
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      left_in  = left_ff;
      col_in   = col_ff;
      case (state_ff)
         ST_IDLE: begin
            if (run_go) begin
               tx_in    = COORD_W'(req.tile_x);
               ty_in    = COORD_W'(req.tile_y);
               left_in  = len_eff;
               col_in   = (req.func == FN_COL_RUN);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (col_ff) begin
               ty_in = ty_ff + COORD_W'(1);
            end else begin
               tx_in = tx_ff + COORD_W'(1);
            end
            left_in = left_ff - LEN_W'(1);
            if (left_ff == LEN_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // split the cursor into metatile cell and sub-tile offset
   always_comb begin
      ux       = tx_ff[UC_W-1:0];
      uy       = ty_ff[UC_W-1:0];
      neg      = tx_ff[COORD_W-1] | ty_ff[COORD_W-1];
      mtx      = ux >> cfg.side_log2;
      mty      = uy >> cfg.side_log2;
      outside  = (mtx >= UC_W'(cfg.map_width)) || (mty >= UC_W'(cfg.map_height));
      map_cell = CELL_W'(mty[6:0]) * CELL_W'(cfg.map_width) + CELL_W'(mtx[6:0]);
      cell_oob = (32'(map_cell) >= MAP_CELLS);
      sub_mask = SUB_W'((4'd1 << cfg.side_log2) - 4'd1);

      tap_in.valid = (state_ff == ST_RUN);
      tap_in.last  = (left_ff == LEN_W'(1));
      tap_in.oob   = neg | outside | cell_oob;
      tap_in.sx    = ux[SUB_W-1:0] & sub_mask;
      tap_in.sy    = uy[SUB_W-1:0] & sub_mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff.valid <= tap_in.valid;
      end
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      left_ff     <= left_in;
      col_ff      <= col_in;
      tap_ff.last <= tap_in.last;
      tap_ff.oob  <= tap_in.oob;
      tap_ff.sx   <= tap_in.sx;
      tap_ff.sy   <= tap_in.sy;
   end

   assign map_raddr = map_cell[MAP_AW-1:0];
   assign tap       = tap_ff;
   assign active    = (state_ff == ST_RUN);

   `MTRF_NEVER(a_run_empty, state_ff == ST_RUN && left_ff == '0)
   `MTRF_ASSERT(a_run_ends, state_ff == ST_RUN && left_ff == LEN_W'(1) |=> state_ff == ST_IDLE)

endmodule

// ===== rtl/mtrf_expand.sv =====
// definition lookup: turns the metatile index into a definition read
// and picks the stored word or the fallback entry; depends on mtrf_pkg
module mtrf_expand import mtrf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  tap_type               tap,
   input  logic [ENTRY_BITS-1:0] map_q,
   input  logic [ENTRY_BITS-1:0] def_q,
   output logic [DEF_AW-1:0]     def_raddr,
   output logic                  pending,
   output logic                  rsp_valid,
   output rsp_type               rsp_data
);

   logic              s2_valid_ff, s2_last_ff, s2_oob_ff;
   logic              bad_index, addr_oob;
   logic [DADDR_W-1:0] addr;
   logic [2:0]        sh2;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   always_comb begin
      sh2       = {cfg.side_log2, 1'b0};
      bad_index = (32'(map_q) >= 32'(cfg.def_limit));
      addr      = (DADDR_W'(map_q) << sh2) + (DADDR_W'(tap.sy) << cfg.side_log2)
                  + DADDR_W'(tap.sx);
      addr_oob  = (32'(addr) >= DEF_WORDS);
   end

   assign def_raddr = addr[DEF_AW-1:0];

   always_comb begin
      rsp_in.last = s2_last_ff;
      if (s2_oob_ff) begin
         rsp_in.tile_entry = cfg.fallback_entry;
      end else begin
         rsp_in.tile_entry = 16'(def_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= tap.valid;
         rsp_valid_ff <= s2_valid_ff;
      end
      s2_last_ff <= tap.last;
      s2_oob_ff  <= tap.oob | bad_index | addr_oob;
      rsp_ff     <= rsp_in;
   end

   assign pending   = s2_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
